>>> rtl/core/assembly_source_lexer_defines.svh
// Assertion macros shared by the assembly source lexer modules.
`ifndef ASSEMBLY_SOURCE_LEXER_DEFINES_SVH
`define ASSEMBLY_SOURCE_LEXER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ASL_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define ASL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/asl_pkg.sv
// Types, constants and character classes of the assembly source lexer.
`default_nettype none

package asl_pkg;

    typedef enum logic [3:0] {
        TT_EOF     = 4'd0,
        TT_EOL     = 4'd1,
        TT_IDENT   = 4'd2,
        TT_DIR     = 4'd3,
        TT_NUM     = 4'd4,
        TT_COLON   = 4'd5,
        TT_COMMA   = 4'd6,
        TT_QMARK   = 4'd7,
        TT_LPAREN  = 4'd8,
        TT_RPAREN  = 4'd9,
        TT_LBRACK  = 4'd10,
        TT_RBRACK  = 4'd11,
        TT_UNARY   = 4'd12,
        TT_BINARY  = 4'd13,
        TT_PM      = 4'd14,
        TT_ERROR   = 4'd15
    } tok_type_t;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_DIR, M_ZERO, M_BIN, M_OCT, M_DEC, M_HEX,
        M_COMMENT, M_CR, M_BSLASH, M_BSCR,
        M_LT, M_GT, M_EQ, M_AMP, M_BAR, M_BANG
    } mode_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int START_W = 32;
    localparam int LEN_W   = 16;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        tok_type_t            ttype;
        logic [START_W-1:0]   start;
        logic [LEN_W-1:0]     length;
        logic                 last;
    } tok_t;

    typedef struct packed {
        logic vld0;
        logic vld1;
        tok_t tok0;
        tok_t tok1;
    } q_push_t;

    typedef struct packed {
        logic      emit;
        tok_type_t ttype;
        mode_t     mode;
        logic      load;
        logic      skip_marker;
        logic      len_one;
    } idle_t;

    typedef struct packed {
        logic      emit;
        tok_type_t ttype;
        logic      use_pending;
    } flush_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_" || c == "@";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") || c == "_";
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return c == CH_LF || c == CH_CR || c == CH_FF || c == CH_VT;
    endfunction

    function automatic logic absorbs(input mode_t m, input logic [7:0] c);
        logic r;
        case (m)
            M_IDENT, M_DIR: r = is_ident(c);
            M_BIN:          r = c == "0" || c == "1" || c == "_";
            M_ZERO, M_OCT:  r = (c >= "0" && c <= "7") || c == "_";
            M_DEC:          r = is_digit(c) || c == "_";
            M_HEX:          r = is_hex(c);
            default:        r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic pair_with(input mode_t m, input logic [7:0] c);
        logic r;
        case (m)
            M_LT:           r = c == "<" || c == "=";
            M_GT:           r = c == ">" || c == "=";
            M_EQ, M_BANG:   r = c == "=";
            M_AMP:          r = c == "&";
            M_BAR:          r = c == "|";
            default:        r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic flush_t flush_class(input mode_t m);
        flush_t r;
        r.emit        = 1'b1;
        r.use_pending = 1'b0;
        r.ttype       = TT_ERROR;
        case (m)
            M_IDENT:
            begin
                r.ttype       = TT_IDENT;
                r.use_pending = 1'b1;
            end
            M_DIR:
            begin
                r.ttype       = TT_DIR;
                r.use_pending = 1'b1;
            end
            M_ZERO, M_BIN, M_OCT, M_DEC, M_HEX:
            begin
                r.ttype       = TT_NUM;
                r.use_pending = 1'b1;
            end
            M_LT, M_GT, M_EQ, M_AMP, M_BAR: r.ttype = TT_BINARY;
            M_BANG:   r.ttype = TT_UNARY;
            M_CR:     r.ttype = TT_EOL;
            M_BSLASH: r.ttype = TT_ERROR;
            default:  r.emit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic idle_t idle_class(input logic [7:0] c);
        idle_t r;
        r.emit        = 1'b0;
        r.ttype       = TT_ERROR;
        r.mode        = M_IDLE;
        r.load        = 1'b0;
        r.skip_marker = 1'b0;
        r.len_one     = 1'b1;
        if (c == CH_SPACE || c == CH_TAB)
        begin
            r.emit = 1'b0;
        end
        else if (is_alpha(c) || c == "_" || c == "@")
        begin
            r.mode = M_IDENT;
            r.load = 1'b1;
        end
        else if (c >= "1" && c <= "9")
        begin
            r.mode = M_DEC;
            r.load = 1'b1;
        end
        else if (c == "." || c == "#")
        begin
            r.mode        = M_DIR;
            r.load        = 1'b1;
            r.skip_marker = 1'b1;
            r.len_one     = 1'b0;
        end
        else if (c == "0")
        begin
            r.mode = M_ZERO;
            r.load = 1'b1;
        end
        else if (c == "$")
        begin
            r.mode = M_HEX;
            r.load = 1'b1;
        end
        else if (c == ";")
        begin
            r.mode = M_COMMENT;
        end
        else if (c == "<" || c == ">" || c == "=" || c == "&" || c == "|" || c == "!"
                 || c == CH_CR || c == "\\")
        begin
            r.load = 1'b1;
            case (c)
                "<":     r.mode = M_LT;
                ">":     r.mode = M_GT;
                "=":     r.mode = M_EQ;
                "&":     r.mode = M_AMP;
                "|":     r.mode = M_BAR;
                "!":     r.mode = M_BANG;
                CH_CR:   r.mode = M_CR;
                default: r.mode = M_BSLASH;
            endcase
        end
        else
        begin
            r.emit = 1'b1;
            case (c)
                ":":                   r.ttype = TT_COLON;
                ",":                   r.ttype = TT_COMMA;
                "?":                   r.ttype = TT_QMARK;
                "(":                   r.ttype = TT_LPAREN;
                ")":                   r.ttype = TT_RPAREN;
                "[":                   r.ttype = TT_LBRACK;
                "]":                   r.ttype = TT_RBRACK;
                "~":                   r.ttype = TT_UNARY;
                "+", "-":              r.ttype = TT_PM;
                "*", "/", "%", "^":    r.ttype = TT_BINARY;
                CH_LF, CH_FF, CH_VT:   r.ttype = TT_EOL;
                default:               r.ttype = TT_ERROR;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/asl_front.sv
// Lexer front end: accepts source bytes, steps the token state machine, pushes descriptors.
`default_nettype none
`include "assembly_source_lexer_defines.svh"

module asl_front #(
    parameter int LENGTH_WIDTH = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          char_code,
    input  wire logic                end_of_input,
    input  wire logic                q_room,
    output asl_pkg::q_push_t         push
);

    localparam int OW_EXT = (OFFSET_WIDTH > asl_pkg::START_W) ? OFFSET_WIDTH : asl_pkg::START_W;
    localparam int LW_EXT = (LENGTH_WIDTH > asl_pkg::LEN_W) ? LENGTH_WIDTH : asl_pkg::LEN_W;
    localparam logic [LENGTH_WIDTH-1:0] LEN_SAT = '1;

    asl_pkg::mode_t              mode_reg, mode_next;
    logic [OFFSET_WIDTH-1:0]     pstart_reg, pstart_next;
    logic [LENGTH_WIDTH-1:0]     plen_reg, plen_next;
    logic [OFFSET_WIDTH-1:0]     offset_reg, offset_next;

    logic                        accept;
    asl_pkg::idle_t              ic;
    asl_pkg::flush_t             fl;
    logic                        idle_en;
    logic                        flush_en;
    logic                        pair_en;
    logic                        generic;
    logic                        grow;
    asl_pkg::tok_type_t          pair_type;
    logic                        a_vld;
    logic                        b_vld;
    asl_pkg::tok_t               tok_a;
    asl_pkg::tok_t               tok_b;
    logic [OW_EXT-1:0]           ps_ext;
    logic [OW_EXT-1:0]           pos_ext;
    logic [LW_EXT-1:0]           len_ext;
    logic [asl_pkg::START_W-1:0] ps32;
    logic [asl_pkg::START_W-1:0] pos32;
    logic [asl_pkg::LEN_W-1:0]   plen16;

    assign in_ready = q_room;
    assign accept   = in_valid && q_room;

    assign ps_ext  = OW_EXT'(pstart_reg);
    assign pos_ext = OW_EXT'(offset_reg);
    assign len_ext = LW_EXT'(plen_reg);
    assign ps32    = ps_ext[asl_pkg::START_W-1:0];
    assign pos32   = pos_ext[asl_pkg::START_W-1:0];
    assign plen16  = (len_ext > LW_EXT'({asl_pkg::LEN_W{1'b1}})) ? {asl_pkg::LEN_W{1'b1}}
                                                                : len_ext[asl_pkg::LEN_W-1:0];

    assign ic = asl_pkg::idle_class(char_code);
    assign fl = asl_pkg::flush_class(mode_reg);

    always_comb
    begin
        mode_next = mode_reg;
        idle_en   = 1'b0;
        generic   = 1'b0;
        pair_en   = 1'b0;
        grow      = 1'b0;
        pair_type = asl_pkg::TT_BINARY;
        case (mode_reg)
            asl_pkg::M_IDLE:
            begin
                idle_en = 1'b1;
            end
            asl_pkg::M_COMMENT:
            begin
                idle_en = asl_pkg::is_eol(char_code);
            end
            asl_pkg::M_BSLASH:
            begin
                if (char_code == asl_pkg::CH_CR)
                begin
                    mode_next = asl_pkg::M_BSCR;
                end
                else if (asl_pkg::is_eol(char_code))
                begin
                    mode_next = asl_pkg::M_IDLE;
                end
                else
                begin
                    generic = 1'b1;
                end
            end
            asl_pkg::M_BSCR:
            begin
                mode_next = asl_pkg::M_IDLE;
                idle_en   = char_code != asl_pkg::CH_LF;
            end
            asl_pkg::M_CR:
            begin
                if (char_code == asl_pkg::CH_LF)
                begin
                    pair_en   = 1'b1;
                    pair_type = asl_pkg::TT_EOL;
                    mode_next = asl_pkg::M_IDLE;
                end
                else
                begin
                    generic = 1'b1;
                end
            end
            asl_pkg::M_LT, asl_pkg::M_GT, asl_pkg::M_EQ,
            asl_pkg::M_AMP, asl_pkg::M_BAR, asl_pkg::M_BANG:
            begin
                if (asl_pkg::pair_with(mode_reg, char_code))
                begin
                    pair_en   = 1'b1;
                    mode_next = asl_pkg::M_IDLE;
                end
                else
                begin
                    generic = 1'b1;
                end
            end
            asl_pkg::M_ZERO:
            begin
                if (char_code == "b")
                begin
                    mode_next = asl_pkg::M_BIN;
                    grow      = 1'b1;
                end
                else if (char_code == "x")
                begin
                    mode_next = asl_pkg::M_HEX;
                    grow      = 1'b1;
                end
                else
                begin
                    generic = 1'b1;
                end
            end
            default:
            begin
                generic = 1'b1;
            end
        endcase

        flush_en = 1'b0;
        if (generic)
        begin
            if (asl_pkg::absorbs(mode_reg, char_code))
            begin
                grow = 1'b1;
                if (mode_reg == asl_pkg::M_ZERO)
                begin
                    mode_next = asl_pkg::M_OCT;
                end
            end
            else
            begin
                flush_en = 1'b1;
                idle_en  = 1'b1;
            end
        end

        if (idle_en)
        begin
            mode_next = ic.mode;
        end
        if (end_of_input)
        begin
            mode_next = asl_pkg::M_IDLE;
        end
    end

    always_comb
    begin
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        offset_next = offset_reg;
        if (accept)
        begin
            if (end_of_input)
            begin
                pstart_next = '0;
                plen_next   = '0;
                offset_next = '0;
            end
            else
            begin
                offset_next = offset_reg + OFFSET_WIDTH'(1);
                if (idle_en && ic.load)
                begin
                    pstart_next = offset_reg + OFFSET_WIDTH'(ic.skip_marker);
                    plen_next   = LENGTH_WIDTH'(ic.len_one);
                end
                else if (grow && plen_reg != LEN_SAT)
                begin
                    plen_next = plen_reg + LENGTH_WIDTH'(1);
                end
            end
        end
    end

    always_comb
    begin
        a_vld        = (end_of_input || flush_en) ? fl.emit : pair_en;
        tok_a.ttype  = (pair_en && !end_of_input) ? pair_type : fl.ttype;
        tok_a.start  = ps32;
        tok_a.length = (pair_en && !end_of_input) ? asl_pkg::LEN_W'(2)
                     : (fl.use_pending ? plen16 : asl_pkg::LEN_W'(1));
        tok_a.last   = 1'b0;

        b_vld        = end_of_input || (idle_en && ic.emit);
        tok_b.ttype  = end_of_input ? asl_pkg::TT_EOF : ic.ttype;
        tok_b.start  = pos32;
        tok_b.length = end_of_input ? '0 : asl_pkg::LEN_W'(1);
        tok_b.last   = 1'b1;

        push.vld0      = accept && (a_vld || b_vld);
        push.vld1      = accept && a_vld && b_vld;
        push.tok0      = a_vld ? tok_a : tok_b;
        push.tok0.last = !(a_vld && b_vld);
        push.tok1      = tok_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= asl_pkg::M_IDLE;
            pstart_reg <= '0;
            plen_reg   <= '0;
            offset_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
            end
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            offset_reg <= offset_next;
        end
    end

    `ASL_ASSERT_NEXT(a_eof_clears, accept && end_of_input, offset_reg == '0 && mode_reg == asl_pkg::M_IDLE && plen_reg == '0, "end of input did not clear lexer state")

endmodule

`default_nettype wire

>>> rtl/core/asl_queue.sv
// Token queue between lexer front end and output stage: two pushes, one pop per cycle.
`default_nettype none
`include "assembly_source_lexer_defines.svh"

module asl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire asl_pkg::q_push_t push,
    output logic                  room,
    output logic                  head_vld,
    output asl_pkg::tok_t         head,
    input  wire logic             pop
);

    asl_pkg::tok_t                 mem [asl_pkg::QDEPTH];
    logic [asl_pkg::QPTR_W-1:0]    wp_reg, wp_next;
    logic [asl_pkg::QPTR_W-1:0]    rp_reg, rp_next;
    logic [asl_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic [asl_pkg::QPTR_W-1:0]    wp_inc;
    logic [asl_pkg::QCNT_W-1:0]    push_n;

    assign wp_inc   = wp_reg + asl_pkg::QPTR_W'(1);
    assign push_n   = asl_pkg::QCNT_W'(push.vld0) + asl_pkg::QCNT_W'(push.vld1);
    assign room     = count_reg <= asl_pkg::QCNT_W'(asl_pkg::QDEPTH - 2);
    assign head_vld = count_reg != '0;
    assign head     = mem[rp_reg];

    always_comb
    begin
        wp_next    = wp_reg + asl_pkg::QPTR_W'(push_n);
        rp_next    = rp_reg + asl_pkg::QPTR_W'(pop);
        count_next = count_reg + push_n - asl_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.vld0)
        begin
            mem[wp_reg] <= push.tok0;
        end
        if (push.vld1)
        begin
            mem[wp_inc] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    `ASL_ASSERT_NOW(a_no_overfill, count_reg <= asl_pkg::QCNT_W'(asl_pkg::QDEPTH), "token queue overfilled")
    `ASL_ASSERT_NOW(a_push_has_room, !push.vld0 || room, "push into queue without room")
    `ASL_ASSERT_NOW(a_pop_nonempty, !pop || head_vld, "pop from empty token queue")
    `ASL_ASSERT_NOW(a_pair_order, !push.vld1 || (push.vld0 && push.tok1.last && !push.tok0.last), "second token of a byte misordered")

endmodule

`default_nettype wire

>>> rtl/core/asl_back.sv
// Output stage: drains the token queue into a registered stream transaction.
`default_nettype none

module asl_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_vld,
    input  wire asl_pkg::tok_t    head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output asl_pkg::tok_t         out_tok
);

    logic          vld_reg, vld_next;
    asl_pkg::tok_t tok_reg;

    assign pop       = head_vld && (!vld_reg || out_ready);
    assign out_valid = vld_reg;
    assign out_tok   = tok_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (pop)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tok_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/assembly_source_lexer.sv
// Top level of the assembly source lexer: byte stream in, token descriptor stream out.
//
// Input channel (s_*): one source byte per transaction in s_tdata; s_tuser set marks
// end of input, which flushes the pending token, emits an EOF token and restarts
// offsets at zero for the next source.
// Output channel (m_*): one token descriptor per transaction; m_tlast marks the last
// token caused by one input transaction. A byte yields zero, one or two tokens.
// Throughput: one input transaction per cycle while bytes yield at most one token each
// and m_tready stays high; the output moves one token per cycle while m_tready is high,
// so bytes that yield two tokens slow the input to the output rate. The lexer state
// machine steps once per accepted byte. Path: a token completed by an input transaction
// is pushed into the token queue by the front-end step and then moved into the output
// register, which drives the output channel.
// Backpressure: a four-entry token queue sits between the front end and the output
// register; s_tready drops when fewer than two entries are free, so a stalled
// receiver stalls the source and nothing is lost.
// Reset: asynchronous, active low; clears the lexer state, byte offset and queue.
`default_nettype none

module assembly_source_lexer #(
    parameter int LENGTH_WIDTH = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] char_code
    input  wire logic         s_tuser,   // [0] end_of_input
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,   // [3:0] token_type, [35:4] token_start,
                                         // [51:36] token_length, [55:52] zero
    output logic              m_tlast
);

    asl_pkg::q_push_t push;
    logic             room;
    logic             head_vld;
    asl_pkg::tok_t    head;
    logic             pop;
    asl_pkg::tok_t    out_tok;

    asl_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .char_code    (s_tdata),
        .end_of_input (s_tuser),
        .q_room       (room),
        .push         (push)
    );

    asl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .head_vld (head_vld),
        .head     (head),
        .pop      (pop)
    );

    asl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_vld  (head_vld),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = {4'b0000, out_tok.length, out_tok.start, out_tok.ttype};
    assign m_tlast = out_tok.last;

endmodule

`default_nettype wire
